// File: sv/mtshd_pkg.sv
// Shared types and constants for the multi-tier sensor history decimator.
package mtshd_pkg;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_PUSH
    } t_state;

    // One stored or emitted record (also the RAM word)
    typedef struct packed {
        logic [31:0]        rtime;
        logic signed [15:0] at;
        logic signed [15:0] ct;
        logic signed [15:0] lt;
        logic signed [15:0] st;
        logic [13:0]        ah;
        logic               lamp;
    } t_rec;

    // Register indexes on the config port
    localparam logic [1:0] REG_T0_INTV = 2'd0;
    localparam logic [1:0] REG_T1_INTV = 2'd1;
    localparam logic [1:0] REG_T2_INTV = 2'd2;

    localparam logic [3:0] T0_INTV_RST = 4'd6;
    localparam logic [3:0] T1_INTV_RST = 4'd10;
    localparam logic [3:0] T2_INTV_RST = 4'd12;

    // Sum lanes: at, ct, lt, st, ah
    localparam int NLANE = 5;
    localparam int SUMW  = 20;   // 15 x 16-bit signed fits
    localparam int DIVW  = 21;   // 2*|sum| + n
    localparam int RCPW  = 25;   // reciprocal of 2n, 2n >= 4
    localparam int RCPSH = 26;   // 2^RCPSH > 2^21 * 30 keeps the quotient exact

endpackage

// File: sv/multi_tier_sensor_history_decimator.sv
// Top level: four-tier averaging history of timestamped sensor samples.
// Flow: a sample that cascades into k tiers (k = 0..3) first has each of the k
//   averaged tiers walked in turn through the single RAM read port; its records
//   are then pushed and presented deepest tier first, each further one once taken.
// Throughput: one item at a time; the next item is accepted only after the push
//   into tier 0, so output stalls and the single RAM read port walking each
//   averaged tier both delay it.
// Reset: synchronous, active low; empties all tiers, clears interval
//   counters and loads the default intervals. History RAM is not cleared.
module multi_tier_sensor_history_decimator #(
    parameter int TIER0_DEPTH = 6,
    parameter int TIER1_DEPTH = 10,
    parameter int TIER2_DEPTH = 12,
    parameter int TIER3_DEPTH = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample in
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_sample_time,
    input  logic signed [15:0] i_ambient_temp,
    input  logic [13:0]        i_ambient_humidity,
    input  logic signed [15:0] i_chamber_temp,
    input  logic signed [15:0] i_led_temp,
    input  logic signed [15:0] i_screen_temp,
    input  logic               i_lamp_on,
    // record out
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_tier,
    output logic [31:0]        o_rec_time,
    output logic signed [15:0] o_rec_ambient_temp,
    output logic [13:0]        o_rec_ambient_humidity,
    output logic signed [15:0] o_rec_chamber_temp,
    output logic signed [15:0] o_rec_led_temp,
    output logic signed [15:0] o_rec_screen_temp,
    output logic               o_rec_lamp_on,
    output logic               o_last,
    // config
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import mtshd_pkg::*;

    localparam int TOTAL = TIER0_DEPTH + TIER1_DEPTH + TIER2_DEPTH + TIER3_DEPTH;
    localparam int AW    = $clog2(TOTAL);

    // per-tier geometry of the shared history RAM
    localparam logic [3:0] DEPTH [4] = '{4'(TIER0_DEPTH), 4'(TIER1_DEPTH),
                                         4'(TIER2_DEPTH), 4'(TIER3_DEPTH)};
    localparam logic [AW-1:0] BASE [4] = '{
        AW'(0), AW'(TIER0_DEPTH), AW'(TIER0_DEPTH + TIER1_DEPTH),
        AW'(TIER0_DEPTH + TIER1_DEPTH + TIER2_DEPTH)};

    // per-tier reciprocal of 2n, rounded up
    localparam logic [RCPW-1:0] RECIP [4] = '{
        RCPW'((1 << RCPSH) / (2 * TIER0_DEPTH) + 1),
        RCPW'((1 << RCPSH) / (2 * TIER1_DEPTH) + 1),
        RCPW'((1 << RCPSH) / (2 * TIER2_DEPTH) + 1),
        RCPW'((1 << RCPSH) / (2 * TIER3_DEPTH) + 1)};

    // ---------------- control state ----------------
    t_state      r_state, n_state;
    logic [3:0]  r_head [4];
    logic [3:0]  r_fill [4];
    logic [3:0]  r_cnt  [3];
    logic [3:0]  r_intv [3];
    logic [1:0]  r_tier;     // tier being averaged, then tier being pushed
    logic [1:0]  r_k;        // number of tiers that average for this item
    logic [3:0]  r_idx;      // entry walk index during reads
    logic        r_dv;       // RAM read data valid this cycle
    logic        r_first;    // that data is the oldest entry
    logic        r_oval;

    // ---------------- payload ----------------
    t_rec                   r_smp;
    t_rec                   r_avg [3];
    t_rec                   r_out;
    logic [1:0]             r_otier;
    logic signed [SUMW-1:0] r_sum [NLANE];
    logic [3:0]             r_lsum;
    logic [31:0]            r_atime;
    logic                   r_neg [NLANE];
    logic [DIVW-1:0]        r_dvd [NLANE];

    // ---------------- RAM ----------------
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_addr;
    t_rec          ram_wdata, ram_rdata;

    mtshd_ram #(.WIDTH($bits(t_rec)), .DEPTH(TOTAL)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // ---------------- handshakes ----------------
    logic in_acc, out_acc, push_fire, issue, cfg_wr;
    assign o_ready   = (r_state == ST_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign out_acc   = r_oval && i_ready;
    assign push_fire = (r_state == ST_PUSH) && (!r_oval || i_ready);
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;

    // cascade depth: tier t averages when full, counter reached, and t-1 cascades
    logic c0, c1, c2;
    assign c0 = (r_fill[0] == DEPTH[0]) && (r_cnt[0] >= r_intv[0]);
    assign c1 = c0 && (r_fill[1] == DEPTH[1]) && (r_cnt[1] >= r_intv[1]);
    assign c2 = c1 && (r_fill[2] == DEPTH[2]) && (r_cnt[2] >= r_intv[2]);

    // current tier view
    logic [3:0] cur_n, cur_head, cur_fill;
    logic       cur_full;
    assign cur_n    = DEPTH[r_tier];
    assign cur_head = r_head[r_tier];
    assign cur_fill = r_fill[r_tier];
    assign cur_full = (cur_fill == cur_n);

    assign issue = (r_state == ST_READ) && (r_idx < cur_n);

    // record pushed into the current tier
    t_rec push_rec;
    assign push_rec = (r_tier == 2'd0) ? r_smp : r_avg[r_tier - 2'd1];

    // ring slot: base + (head + pos) mod depth, pos < depth
    logic [3:0] pos;
    logic [4:0] ring_sum, ring_pos;
    always_comb begin
        pos      = (r_state == ST_PUSH) ? (cur_full ? 4'd0 : cur_fill) : r_idx;
        ring_sum = {1'b0, cur_head} + {1'b0, pos};
        ring_pos = (ring_sum >= {1'b0, cur_n}) ? ring_sum - {1'b0, cur_n} : ring_sum;
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = c0 ? ST_READ : ST_PUSH;
                end
            end
            ST_READ: begin
                if (r_idx == cur_n && !r_dv) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_state = (2'(r_tier + 2'd1) == r_k) ? ST_PUSH : ST_READ;
            end
            ST_PUSH: begin
                if (push_fire && r_tier == 2'd0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- state outputs (RAM port) ----------------
    always_comb begin
        ram_re    = issue;
        ram_we    = push_fire;
        ram_addr  = BASE[r_tier] + AW'(ring_pos);
        ram_wdata = push_rec;
    end

    // ---------------- rounded mean: (2|s| + n) / 2n by reciprocal multiply ----------------
    logic [DIVW-1:0]      ld_dvd [NLANE];
    logic [SUMW-1:0]      mag    [NLANE];
    logic [DIVW+RCPW-1:0] prod   [NLANE];
    logic [DIVW-1:0]      quo    [NLANE];
    logic [DIVW-1:0]      qres   [NLANE];
    logic [RCPW-1:0]      rcp;
    always_comb begin
        rcp = RECIP[r_tier];
        for (int l = 0; l < NLANE; l++) begin
            mag[l]    = r_sum[l][SUMW-1] ? SUMW'(-r_sum[l]) : SUMW'(r_sum[l]);
            ld_dvd[l] = {mag[l], 1'b0} + DIVW'(cur_n);
            prod[l]   = (DIVW+RCPW)'(r_dvd[l]) * (DIVW+RCPW)'(rcp);
            quo[l]    = DIVW'(prod[l] >> RCPSH);
            qres[l]   = r_neg[l] ? DIVW'(-quo[l]) : quo[l];
        end
    end

    // ---------------- datapath and control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int t = 0; t < 4; t++) begin
                r_head[t] <= '0;
                r_fill[t] <= '0;
            end
            for (int t = 0; t < 3; t++) begin
                r_cnt[t] <= '0;
            end
            r_intv[0] <= T0_INTV_RST;
            r_intv[1] <= T1_INTV_RST;
            r_intv[2] <= T2_INTV_RST;
            r_tier  <= '0;
            r_k     <= '0;
            r_idx   <= '0;
            r_dv    <= 1'b0;
            r_first <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= issue;
            r_first <= issue && (r_idx == 4'd0);

            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_T0_INTV: r_intv[0] <= pwdata[3:0];
                    REG_T1_INTV: r_intv[1] <= pwdata[3:0];
                    REG_T2_INTV: r_intv[2] <= pwdata[3:0];
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_smp  <= '{i_sample_time, i_ambient_temp, i_chamber_temp, i_led_temp,
                            i_screen_temp, i_ambient_humidity, i_lamp_on};
                r_k    <= {1'b0, c0} + {1'b0, c1} + {1'b0, c2};
                r_tier <= (c0 && c1 && c2) ? 2'd0 : 2'd0;
                r_idx  <= '0;
                r_lsum <= '0;
                for (int l = 0; l < NLANE; l++) begin
                    r_sum[l] <= '0;
                end
            end

            // walk the tier: issue reads, accumulate returned entries
            if (issue) begin
                r_idx <= r_idx + 4'd1;
            end
            if (r_dv) begin
                r_sum[0] <= r_sum[0] + SUMW'(ram_rdata.at);
                r_sum[1] <= r_sum[1] + SUMW'(ram_rdata.ct);
                r_sum[2] <= r_sum[2] + SUMW'(ram_rdata.lt);
                r_sum[3] <= r_sum[3] + SUMW'(ram_rdata.st);
                r_sum[4] <= r_sum[4] + SUMW'({1'b0, ram_rdata.ah});
                r_lsum   <= r_lsum + {3'b0, ram_rdata.lamp};
                if (r_first) begin
                    r_atime <= ram_rdata.rtime;
                end
            end

            // load dividends: 2|s| + n
            if (r_state == ST_READ && n_state == ST_DIV) begin
                for (int l = 0; l < NLANE; l++) begin
                    r_neg[l] <= r_sum[l][SUMW-1];
                    r_dvd[l] <= ld_dvd[l];
                end
            end

            if (r_state == ST_DIV) begin
                r_avg[r_tier] <= '{r_atime, qres[0][15:0], qres[1][15:0],
                                   qres[2][15:0], qres[3][15:0], qres[4][13:0],
                                   (r_lsum >= {1'b0, cur_n[3:1]})};
                // next tier to average, or deepest tier to push into
                r_tier <= 2'(r_tier + 2'd1);
                r_idx  <= '0;
                r_lsum <= '0;
                for (int l = 0; l < NLANE; l++) begin
                    r_sum[l] <= '0;
                end
            end

            // pushes, deepest tier first; full tier overwrites its oldest slot
            if (push_fire) begin
                r_out   <= push_rec;
                r_otier <= r_tier;
                r_oval  <= 1'b1;
                if (cur_full) begin
                    r_head[r_tier] <= (cur_head == cur_n - 4'd1) ? 4'd0 : cur_head + 4'd1;
                end else begin
                    r_fill[r_tier] <= cur_fill + 4'd1;
                end
                if (r_tier != 2'd3) begin
                    if (!cur_full) begin
                        r_cnt[r_tier] <= r_intv[r_tier];
                    end else if (r_tier < r_k) begin
                        r_cnt[r_tier] <= '0;
                    end else begin
                        r_cnt[r_tier] <= r_cnt[r_tier] + 4'd1;
                    end
                end
                if (r_tier != 2'd0) begin
                    r_tier <= r_tier - 2'd1;
                end
            end else if (out_acc) begin
                r_oval <= 1'b0;
            end

            // entering push from idle starts at tier 0 (no cascade)
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_T0_INTV: prdata = {28'b0, r_intv[0]};
            REG_T1_INTV: prdata = {28'b0, r_intv[1]};
            REG_T2_INTV: prdata = {28'b0, r_intv[2]};
            default:     prdata = '0;
        endcase
    end

    assign o_valid                = r_oval;
    assign o_tier                 = r_otier;
    assign o_rec_time             = r_out.rtime;
    assign o_rec_ambient_temp     = r_out.at;
    assign o_rec_ambient_humidity = r_out.ah;
    assign o_rec_chamber_temp     = r_out.ct;
    assign o_rec_led_temp         = r_out.lt;
    assign o_rec_screen_temp      = r_out.st;
    assign o_rec_lamp_on          = r_out.lamp;
    assign o_last                 = (r_otier == 2'd0);

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("sequencer idle right after accepting an item");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill[0] <= DEPTH[0]) && (r_fill[1] <= DEPTH[1]) &&
        (r_fill[2] <= DEPTH[2]) && (r_fill[3] <= DEPTH[3]))
        else $error("tier fill count beyond depth");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_fire && r_tier != 2'd0) |=> (r_state == ST_PUSH))
        else $error("push sequence ended before tier 0");

endmodule

// File: sv/mtshd_ram.sv
// Generic single-port-write, registered-read RAM.
module mtshd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
